// ----- rtl/zpsf_pkg.sv -----
// Shared types and constants of the zero-phase symmetric FIR filter.
// Used by zpsf_mac, zero_phase_symmetric_fir and the testbench; depends on nothing else.
package zpsf_pkg;

	// Default values of the top-level parameters.
	localparam int HALF_TAPS_DEF      = 63;
	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int COEF_FRAC_BITS_DEF = 16;

	// Fixed field widths.
	localparam int TAP_BITS  = 6;
	localparam int SEEN_BITS = 7;
	localparam logic [SEEN_BITS-1:0] SEEN_MAX = 7'd127;

	// Item kinds carried in tuser of the input stream.
	localparam logic OP_COEF   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_NEXT,
		ST_PUSH_ZERO
	} seq_state_t;

	// Control that travels alongside one tap-pair read into the MAC pipeline.
	typedef struct packed {
		logic valid;     // a tap pair is in this stage
		logic first;     // centre tap, restarts the accumulator
		logic last_term; // final tap pair of this output
		logic use_a;     // lower window sample lies inside the signal
		logic use_b;     // upper window sample lies inside the signal and is paired
		logic coef_ok;   // coefficient entry has been written since reset
		logic last_out;  // this output closes the signal
	} term_ctl_t;

endpackage

// ----- rtl/zero_phase_symmetric_fir.sv -----
// Top level of the zero-phase symmetric FIR filter: stream ports, sample and coefficient
// memories and the tap sequencer. Depends on zpsf_pkg and zpsf_mac.
//
// Usage. The input stream carries two kinds of transaction, told apart by s_axis_tuser:
// a coefficient load writes one tap of the coefficient memory and yields nothing; a
// sample transaction pushes one sample into the window memory and produces the output
// that lies taps_in_use samples back, once more than taps_in_use samples have arrived.
// A sample with s_axis_tlast set also flushes every pending output (zeros are pushed
// behind the signal), marks the final one with m_axis_tlast and then empties the window.
// The user writes the tap count over the cfg channel only while the filter is idle;
// the block itself does not enforce this.
//
// Sequencing. The input is taken only while the sequencer is idle. A coefficient load
// leaves it idle, and a sample that yields no output passes through ST_NEXT back to
// idle. A sample with an output passes through its acceptance, one read per symmetric
// tap pair (taps_in_use + 1 of them, set by the two read ports of the window memory and
// the single multiplier), the sum, multiply and accumulate registers, the load of the
// output register and the return to idle. A flushing sample adds a zero push for each
// zero and the same steps for each flushed output. Reset clears the tap count, the
// sample count and the coefficient valid bits, so all coefficients read as zero until
// loaded. When the receiver stalls, the finished result waits in the output register
// and the next input is still taken; the sequencer stops only when a further result
// has to wait for that register.
module zero_phase_symmetric_fir #(
	parameter int HALF_TAPS      = zpsf_pkg::HALF_TAPS_DEF,
	parameter int SAMPLE_BITS    = zpsf_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = zpsf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// coef_index, coef_value, sample (lowest bits first), zero padded to whole bytes
	input  logic [((zpsf_pkg::TAP_BITS+COEF_FRAC_BITS+2+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// operation
	input  logic s_axis_tuser,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// filtered, zero padded to whole bytes
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	// saturated
	output logic m_axis_tuser,
	output logic m_axis_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [zpsf_pkg::TAP_BITS-1:0] cfg_data
);

	localparam int TAP_BITS      = zpsf_pkg::TAP_BITS;
	localparam int SEEN_BITS     = zpsf_pkg::SEEN_BITS;
	localparam int COEF_BITS     = COEF_FRAC_BITS + 2;
	localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int WIN_LEN       = 2 * HALF_TAPS + 1;
	localparam int WP_BITS       = $clog2(WIN_LEN);
	localparam int WIN_DEPTH     = 1 << WP_BITS;
	localparam int FILL_BITS     = $clog2(WIN_LEN + 1);
	localparam int COEF_DEPTH    = HALF_TAPS + 1;
	localparam int CIDX_BITS     = $clog2(COEF_DEPTH);

	// Input fields.
	logic                          operation;
	logic [TAP_BITS-1:0]           coef_index;
	logic signed [COEF_BITS-1:0]   coef_value;
	logic signed [SAMPLE_BITS-1:0] sample;

	assign operation  = s_axis_tuser;
	assign coef_index = s_axis_tdata[TAP_BITS-1:0];
	assign coef_value = s_axis_tdata[TAP_BITS +: COEF_BITS];
	assign sample     = s_axis_tdata[TAP_BITS+COEF_BITS +: SAMPLE_BITS];

	// Memories: the sample window is a circular buffer, newest sample just below wp_q.
	logic signed [SAMPLE_BITS-1:0] win_mem [WIN_DEPTH];
	logic signed [COEF_BITS-1:0]   coef_mem [COEF_DEPTH];
	logic [COEF_DEPTH-1:0]         coef_vld_q;

	zpsf_pkg::seq_state_t state_q, state_d;
	logic [TAP_BITS-1:0]  taps_q;
	logic [SEEN_BITS-1:0] seen_q;
	logic [FILL_BITS-1:0] fill_q;
	logic [WP_BITS-1:0]   wp_q;
	logic [TAP_BITS-1:0]  k_q;
	logic [TAP_BITS-1:0]  i_q;
	logic                 last_q;

	logic signed [SAMPLE_BITS-1:0] win_a_s1, win_b_s1;
	logic signed [COEF_BITS-1:0]   coef_s1;
	zpsf_pkg::term_ctl_t           ctl_s1;

	logic                          in_fire;
	logic                          coef_we;
	logic                          push_sample;
	logic                          push_zero;
	logic                          win_we;
	logic signed [SAMPLE_BITS-1:0] win_wdata;
	logic                          issue;
	logic                          clear_run;
	logic [TAP_BITS-1:0]           t_eff;
	logic [SEEN_BITS-1:0]          seen_inc;
	logic [SEEN_BITS:0]            flush_pos;
	logic [TAP_BITS-1:0]           ja;
	logic [TAP_BITS:0]             jb;
	logic [WP_BITS-1:0]            addr_a, addr_b;
	logic                          mac_done;
	logic signed [SAMPLE_BITS-1:0] filtered;

	// A tap count beyond the window is clamped to the largest one it holds.
	assign t_eff = (taps_q > TAP_BITS'(HALF_TAPS)) ? TAP_BITS'(HALF_TAPS) : taps_q;

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign coef_we   = in_fire && (operation == zpsf_pkg::OP_COEF) &&
	                   (coef_index <= TAP_BITS'(HALF_TAPS));
	assign seen_inc  = (seen_q == zpsf_pkg::SEEN_MAX) ? seen_q : seen_q + SEEN_BITS'(1);
	// Samples held once the next zero is pushed during a flush.
	assign flush_pos = (SEEN_BITS+1)'(seen_q) + (SEEN_BITS+1)'(i_q) + (SEEN_BITS+1)'(1);

	assign s_axis_tready = (state_q == zpsf_pkg::ST_IDLE);
	assign cfg_ready     = 1'b1;

	// Sequencer: push a sample, read tap pairs k = 0..t, wait for the result, and in a
	// flush repeat with zero pushes until t zeros have gone in.
	always_comb begin
		state_d     = state_q;
		push_sample = 1'b0;
		push_zero   = 1'b0;
		issue       = 1'b0;
		clear_run   = 1'b0;
		case (state_q)
			zpsf_pkg::ST_IDLE: begin
				if (in_fire && (operation == zpsf_pkg::OP_SAMPLE)) begin
					push_sample = 1'b1;
					if (seen_inc > SEEN_BITS'(t_eff)) begin
						state_d = zpsf_pkg::ST_ISSUE;
					end else begin
						state_d = zpsf_pkg::ST_NEXT;
					end
				end
			end
			zpsf_pkg::ST_ISSUE: begin
				issue = 1'b1;
				if (k_q == t_eff) begin
					state_d = zpsf_pkg::ST_WAIT;
				end
			end
			zpsf_pkg::ST_WAIT: begin
				if (mac_done) begin
					state_d = zpsf_pkg::ST_NEXT;
				end
			end
			zpsf_pkg::ST_NEXT: begin
				if (last_q && (i_q != t_eff)) begin
					state_d = zpsf_pkg::ST_PUSH_ZERO;
				end else begin
					clear_run = last_q;
					state_d   = zpsf_pkg::ST_IDLE;
				end
			end
			zpsf_pkg::ST_PUSH_ZERO: begin
				push_zero = 1'b1;
				if (flush_pos > (SEEN_BITS+1)'(t_eff)) begin
					state_d = zpsf_pkg::ST_ISSUE;
				end else begin
					state_d = zpsf_pkg::ST_NEXT;
				end
			end
			default: begin
				state_d = zpsf_pkg::ST_IDLE;
			end
		endcase
	end

	assign win_we    = push_sample || push_zero;
	assign win_wdata = push_sample ? sample : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= zpsf_pkg::ST_IDLE;
			taps_q     <= '0;
			seen_q     <= '0;
			fill_q     <= '0;
			wp_q       <= '0;
			k_q        <= '0;
			i_q        <= '0;
			last_q     <= 1'b0;
			coef_vld_q <= '0;
			ctl_s1     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				taps_q <= cfg_data;
			end
			if (coef_we) begin
				coef_vld_q[coef_index[CIDX_BITS-1:0]] <= 1'b1;
			end
			if (win_we) begin
				wp_q <= wp_q + WP_BITS'(1);
				k_q  <= '0;
				if (fill_q != FILL_BITS'(WIN_LEN)) begin
					fill_q <= fill_q + FILL_BITS'(1);
				end
			end
			if (push_sample) begin
				seen_q <= seen_inc;
				last_q <= s_axis_tlast;
				i_q    <= '0;
			end
			if (push_zero) begin
				i_q <= i_q + TAP_BITS'(1);
			end
			if (issue) begin
				k_q <= k_q + TAP_BITS'(1);
			end
			if (clear_run) begin
				fill_q <= '0;
				seen_q <= '0;
			end
			ctl_s1.valid     <= issue;
			ctl_s1.first     <= (k_q == '0);
			ctl_s1.last_term <= (k_q == t_eff);
			ctl_s1.use_a     <= FILL_BITS'(ja) < fill_q;
			ctl_s1.use_b     <= (k_q != '0) && (FILL_BITS'(jb) < fill_q);
			ctl_s1.coef_ok   <= coef_vld_q[k_q[CIDX_BITS-1:0]];
			ctl_s1.last_out  <= last_q && (i_q == t_eff);
		end
	end

	// Tap pair k reads window positions t-k and t+k, counted back from the newest sample.
	always_comb begin
		ja     = t_eff - k_q;
		jb     = (TAP_BITS+1)'(t_eff) + (TAP_BITS+1)'(k_q);
		addr_a = wp_q - WP_BITS'(1) - WP_BITS'(ja);
		addr_b = wp_q - WP_BITS'(1) - WP_BITS'(jb);
	end

	// Writes and reads of the window never share a cycle: the sequencer issues reads
	// only in the cycles after a push has completed.
	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[wp_q] <= win_wdata;
		end
		if (issue) begin
			win_a_s1 <= win_mem[addr_a];
			win_b_s1 <= win_mem[addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_index[CIDX_BITS-1:0]] <= coef_value;
		end
		if (issue) begin
			coef_s1 <= coef_mem[k_q[CIDX_BITS-1:0]];
		end
	end

	zpsf_mac #(
		.HALF_TAPS      (HALF_TAPS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.term_ctl     (ctl_s1),
		.win_a        (win_a_s1),
		.win_b        (win_b_s1),
		.coef         (coef_s1),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_filtered (filtered),
		.out_sat      (m_axis_tuser),
		.out_last     (m_axis_tlast),
		.done         (mac_done)
	);

	assign m_axis_tdata = OUT_DATA_BITS'($unsigned(filtered));

	assert property (@(posedge clk) disable iff (!arst_n)
		!(win_we && issue))
		else $error("window write and tap read in the same cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == zpsf_pkg::ST_WAIT))
		else $error("result completed while the sequencer was not waiting");

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_BITS'(WIN_LEN))
		else $error("window fill count beyond window length");

endmodule

// ----- rtl/zpsf_mac.sv -----
// Multiply-accumulate pipeline, rounding, saturation and output register of the filter.
// Depends on zpsf_pkg; fed with registered memory read data by zero_phase_symmetric_fir.
module zpsf_mac #(
	parameter int HALF_TAPS      = zpsf_pkg::HALF_TAPS_DEF,
	parameter int SAMPLE_BITS    = zpsf_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = zpsf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  zpsf_pkg::term_ctl_t           term_ctl,
	input  logic signed [SAMPLE_BITS-1:0] win_a,
	input  logic signed [SAMPLE_BITS-1:0] win_b,
	input  logic signed [COEF_FRAC_BITS+1:0] coef,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] out_filtered,
	output logic                          out_sat,
	output logic                          out_last,
	output logic                          done
);

	localparam int COEF_BITS = COEF_FRAC_BITS + 2;
	localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS + 1;
	localparam int ACC_BITS  = PROD_BITS + $clog2(HALF_TAPS + 1) + 1;

	localparam logic signed [ACC_BITS-1:0] RND_HALF =
		{{(ACC_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
	localparam logic signed [ACC_BITS-1:0] SAT_HI =
		{{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] SAT_LO =
		{{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	zpsf_pkg::term_ctl_t           ctl_s2, ctl_s3;
	logic signed [SAMPLE_BITS:0]   sum_s2;
	logic signed [COEF_BITS-1:0]   coef_s2;
	logic signed [PROD_BITS-1:0]   prod_s3;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic                          pend_q;
	logic                          last_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_filtered_q;
	logic                          out_sat_q;
	logic                          out_last_q;

	logic signed [SAMPLE_BITS:0]   a_ext, b_ext;
	logic signed [ACC_BITS-1:0]    rnd, quo;
	logic                          ovf_hi, ovf_lo;
	logic signed [SAMPLE_BITS-1:0] filtered_d;

	// Samples outside the signal and unwritten coefficients count as zero.
	always_comb begin
		a_ext = term_ctl.use_a ? {win_a[SAMPLE_BITS-1], win_a} : '0;
		b_ext = term_ctl.use_b ? {win_b[SAMPLE_BITS-1], win_b} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= term_ctl;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2  <= a_ext + b_ext;
		coef_s2 <= term_ctl.coef_ok ? coef : '0;
		prod_s3 <= sum_s2 * coef_s2;
		if (ctl_s3.valid) begin
			if (ctl_s3.first) begin
				acc_q <= ACC_BITS'(prod_s3);
			end else begin
				acc_q <= acc_q + ACC_BITS'(prod_s3);
			end
		end
	end

	// Round half up is floor(acc + half), then clip to the sample range.
	always_comb begin
		rnd    = acc_q + RND_HALF;
		quo    = rnd >>> COEF_FRAC_BITS;
		ovf_hi = quo > SAT_HI;
		ovf_lo = quo < SAT_LO;
		if (ovf_hi) begin
			filtered_d = SAT_HI[SAMPLE_BITS-1:0];
		end else if (ovf_lo) begin
			filtered_d = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			filtered_d = quo[SAMPLE_BITS-1:0];
		end
	end

	assign done = pend_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl_s3.valid && ctl_s3.last_term) begin
				pend_q <= 1'b1;
				last_q <= ctl_s3.last_out;
			end else if (done) begin
				pend_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_filtered_q <= filtered_d;
			out_sat_q      <= ovf_hi || ovf_lo;
			out_last_q     <= last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_filtered = out_filtered_q;
	assign out_sat      = out_sat_q;
	assign out_last     = out_last_q;

	// A new output's terms must not arrive while the previous result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(term_ctl.valid && pend_q))
		else $error("tap pair entered while a result was pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q)
		else $error("result load did not raise the output valid");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_q) |-> $past(ctl_s3.valid && ctl_s3.last_term))
		else $error("result became pending without its final tap pair");

endmodule

// ----- tb/sv/zpsf_checker.sv -----
// Checker of the zero-phase symmetric FIR filter: follows the input, output and tap-count
// channels, keeps its own filter state and compares every filtered sample field by field.
// Depends on zpsf_pkg.
module zpsf_checker #(
	parameter int HALF_TAPS      = zpsf_pkg::HALF_TAPS_DEF,
	parameter int SAMPLE_BITS    = zpsf_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = zpsf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	// coef_index, coef_value, sample (lowest bits first), zero padded to whole bytes
	input  logic [((zpsf_pkg::TAP_BITS+COEF_FRAC_BITS+2+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// operation
	input  logic s_axis_tuser,
	input  logic s_axis_tlast,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	// filtered, zero padded to whole bytes
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	// saturated
	input  logic m_axis_tuser,
	input  logic m_axis_tlast,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [zpsf_pkg::TAP_BITS-1:0] cfg_data,
	output int   failures,
	output int   pending,
	output int   results_checked,
	output int   saturations
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAP_BITS  = zpsf_pkg::TAP_BITS;
	localparam int COEF_BITS = COEF_FRAC_BITS + 2;
	localparam int WIN_LEN   = 2 * HALF_TAPS + 1;
	localparam int MAX_PRINT = 30;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] filtered;
		logic                          saturated;
		logic                          last_out;
	} fir_out_t;

	logic signed [SAMPLE_BITS-1:0] window [WIN_LEN];
	logic signed [COEF_BITS-1:0]   coef_mem [HALF_TAPS+1];
	int                            seen_count;
	int                            tap_count;
	fir_out_t                      expected_q [$];

	function automatic void shift_sample(logic signed [SAMPLE_BITS-1:0] x);
		for (int i = WIN_LEN - 1; i > 0; i--)
			window[i] = window[i-1];
		window[0] = x;
	endfunction

	// Output centred t samples back in the window, rounded half up and clipped.
	function automatic fir_out_t filter_point(int t);
		longint   acc;
		longint   q;
		longint   hi;
		longint   lo;
		fir_out_t r;
		acc = longint'(coef_mem[0]) * longint'(window[t]);
		for (int k = 1; k <= t; k++)
			acc += longint'(coef_mem[k]) * (longint'(window[t-k]) + longint'(window[t+k]));
		acc += longint'(1) <<< (COEF_FRAC_BITS - 1);
		q = acc >>> COEF_FRAC_BITS;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		lo = -hi - 1;
		r.saturated = 1'b0;
		r.last_out  = 1'b0;
		if (q > hi) begin
			q = hi;
			r.saturated = 1'b1;
		end else if (q < lo) begin
			q = lo;
			r.saturated = 1'b1;
		end
		r.filtered = q[SAMPLE_BITS-1:0];
		return r;
	endfunction

	// One sample enters; queue the normal output and, on the final sample, the flush.
	function automatic void take_sample(logic signed [SAMPLE_BITS-1:0] x, logic closes);
		fir_out_t step_q [$];
		fir_out_t r;
		int       t;
		t = (tap_count > HALF_TAPS) ? HALF_TAPS : tap_count;
		shift_sample(x);
		if (seen_count < int'(zpsf_pkg::SEEN_MAX))
			seen_count++;
		if (seen_count > t)
			step_q.push_back(filter_point(t));
		if (closes) begin
			for (int i = 1; i <= t; i++) begin
				shift_sample('0);
				if (seen_count + i > t)
					step_q.push_back(filter_point(t));
			end
			if (step_q.size() > 0) begin
				r = step_q.pop_back();
				r.last_out = 1'b1;
				step_q.push_back(r);
			end
			foreach (window[i])
				window[i] = '0;
			seen_count = 0;
		end
		foreach (step_q[j])
			expected_q.push_back(step_q[j]);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		failures++;
		if (failures <= MAX_PRINT)
			$display("[%0t] mismatch in %s on result %0d: got %0d, expected %0d",
				$time, what, results_checked, got, want);
	endtask

	task automatic check_result();
		fir_out_t                      want;
		logic signed [SAMPLE_BITS-1:0] got;
		got = m_axis_tdata[SAMPLE_BITS-1:0];
		results_checked++;
		if (m_axis_tuser)
			saturations++;
		if (expected_q.size() == 0) begin
			report_mismatch("unexpected result", longint'(got), longint'(0));
			return;
		end
		want = expected_q.pop_front();
		if (got !== want.filtered)
			report_mismatch("filtered", longint'(got), longint'(want.filtered));
		if (m_axis_tuser !== want.saturated)
			report_mismatch("saturated", longint'(m_axis_tuser), longint'(want.saturated));
		if (m_axis_tlast !== want.last_out)
			report_mismatch("last_out", longint'(m_axis_tlast), longint'(want.last_out));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (window[i])
				window[i] = '0;
			foreach (coef_mem[i])
				coef_mem[i] = '0;
			seen_count      = 0;
			tap_count       = 0;
			expected_q.delete();
			failures        = 0;
			pending         = 0;
			results_checked = 0;
			saturations     = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (cfg_valid && cfg_ready)
				tap_count = int'(cfg_data);
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == zpsf_pkg::OP_COEF) begin
					if (s_axis_tdata[TAP_BITS-1:0] <= HALF_TAPS)
						coef_mem[s_axis_tdata[TAP_BITS-1:0]] =
							s_axis_tdata[TAP_BITS +: COEF_BITS];
				end else begin
					take_sample(s_axis_tdata[TAP_BITS+COEF_BITS +: SAMPLE_BITS], s_axis_tlast);
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

// ----- tb/sv/tb_zero_phase_symmetric_fir.sv -----
// Testbench top of the zero-phase symmetric FIR filter: clock, reset, stimulus and verdict.
// Depends on zpsf_pkg, zero_phase_symmetric_fir and the zpsf_checker beside it.
module tb_zero_phase_symmetric_fir;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CLK_PERIOD   = 10;
	localparam int     TAP_BITS     = zpsf_pkg::TAP_BITS;
	localparam int     HALF_TAPS    = zpsf_pkg::HALF_TAPS_DEF;
	localparam int     SAMPLE_BITS  = zpsf_pkg::SAMPLE_BITS_DEF;
	localparam int     COEF_BITS    = zpsf_pkg::COEF_FRAC_BITS_DEF + 2;
	localparam int     IN_BITS      = ((TAP_BITS + COEF_BITS + SAMPLE_BITS + 7) / 8) * 8;
	localparam int     OUT_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;
	// Quiet time of twice the worst-case cost of one output, to cover any leftover work.
	localparam int     QUIET_CYCLES = 2 * (HALF_TAPS + 8);
	localparam int     PHASE_ITEMS  = 45;
	// Worst case is roughly 400 transactions each flushing 64 outputs; the limit leaves
	// a factor of four on top.
	localparam longint RUN_LIMIT_NS = 64'd80_000_000;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                s_axis_tvalid  = 1'b0;
	logic                s_axis_tready;
	logic [IN_BITS-1:0]  s_axis_tdata   = '0;  // coef_index, coef_value, sample
	logic                s_axis_tuser   = 1'b0; // operation
	logic                s_axis_tlast   = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready  = 1'b0;
	logic [OUT_BITS-1:0] m_axis_tdata;          // filtered
	logic                m_axis_tuser;          // saturated
	logic                m_axis_tlast;
	logic                cfg_valid      = 1'b0;
	logic                cfg_ready;
	logic [TAP_BITS-1:0] cfg_data       = '0;

	int failures;
	int pending;
	int results_checked;
	int saturations;

	// Idle percentages of the current phase, and bookkeeping for the summary.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int taps_now       = 0;
	int loads_sent     = 0;
	int samples_sent   = 0;
	int signals_sent   = 0;
	int tap_settings   = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	zero_phase_symmetric_fir dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	zpsf_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.failures        (failures),
		.pending         (pending),
		.results_checked (results_checked),
		.saturations     (saturations)
	);

	// The receiver decides anew at every falling edge whether it takes a result.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Offers one input transaction and returns right after the edge that accepted it.
	// Fields that the operation does not use carry random bits.
	task automatic send_item(logic op, int idx, int cval, int smp, logic closes);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata                                     = '0;
		s_axis_tdata[TAP_BITS-1:0]                       = idx[TAP_BITS-1:0];
		s_axis_tdata[TAP_BITS +: COEF_BITS]              = cval[COEF_BITS-1:0];
		s_axis_tdata[TAP_BITS+COEF_BITS +: SAMPLE_BITS]  = smp[SAMPLE_BITS-1:0];
		s_axis_tuser                                     = op;
		s_axis_tlast                                     = closes;
		s_axis_tvalid                                    = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (op == zpsf_pkg::OP_COEF)
			loads_sent++;
		else
			samples_sent++;
	endtask

	// The last flag of a coefficient load is ignored by the filter, so it is random here.
	task automatic load_coef(int idx, int cval);
		send_item(zpsf_pkg::OP_COEF, idx, cval, $urandom, 1'($urandom_range(1)));
	endtask

	task automatic send_sample(int smp, logic closes);
		send_item(zpsf_pkg::OP_SAMPLE, $urandom, $urandom, smp, closes);
		if (closes)
			signals_sent++;
	endtask

	// Holds the input back until every expected result has been taken and the pipeline
	// has had time to finish work that produces no result.
	task automatic wait_quiet();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES)
			@(negedge clk);
	endtask

	// The tap count is only rewritten while the filter is idle.
	task automatic set_taps(int taps);
		wait_quiet();
		cfg_data  = taps[TAP_BITS-1:0];
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		taps_now  = taps;
		tap_settings++;
	endtask

	function automatic int rand_sample();
		logic signed [SAMPLE_BITS-1:0] v;
		case ($urandom_range(9))
			0: v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			1: v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			2: v = SAMPLE_BITS'($urandom_range(510) - 255);
			default: v = SAMPLE_BITS'($urandom);
		endcase
		return int'(v);
	endfunction

	// Small coefficients keep many outputs inside the range; full-range ones saturate.
	function automatic int rand_coef();
		logic signed [COEF_BITS-1:0] v;
		case ($urandom_range(9))
			0: v = {1'b0, {(COEF_BITS-1){1'b1}}};
			1: v = {1'b1, {(COEF_BITS-1){1'b0}}};
			2, 3, 4, 5: v = COEF_BITS'($urandom_range(8192) - 4096);
			default: v = COEF_BITS'($urandom);
		endcase
		return int'(v);
	endfunction

	// Loads mostly hit taps that are in use, but any position can be written.
	function automatic int rand_index();
		if ($urandom_range(1) == 0)
			return $urandom_range(taps_now, 0);
		return $urandom_range(HALF_TAPS, 0);
	endfunction

	function automatic int rand_length();
		if ($urandom_range(7) == 0)
			return $urandom_range(80, 20);
		return $urandom_range(10, 1);
	endfunction

	// A run of samples with occasional coefficient loads between them. When closes is
	// clear the signal stays open so that the next settings apply in its middle.
	task automatic send_signal(int len, logic closes);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				load_coef(rand_index(), rand_coef());
			send_sample(rand_sample(), closes && (i == len - 1));
		end
	endtask

	initial begin
		int send_pct [4];
		int recv_pct [4];
		int phase_taps [4];
		int start_count;
		logic mid_done;

		send_pct   = '{0, 76, 0, 11};
		recv_pct   = '{0, 0, 76, 11};
		phase_taps = '{5, 2, 63, 0};
		phase_taps[3] = $urandom_range(40, 6);

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. One tap pair with the extreme coefficients and samples.
		set_taps(1);
		load_coef(0, 131071);
		load_coef(1, -131072);
		load_coef(HALF_TAPS, 12345);
		send_sample(32767, 1'b0);
		send_sample(-32768, 1'b1);
		// A signal of a single sample still yields its flushed output.
		send_sample(0, 1'b1);

		// With only a centre tap of one half, results land exactly on .5 and must round up.
		load_coef(0, 32768);
		load_coef(1, 0);
		set_taps(0);
		send_sample(1, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(3, 1'b1);

		// All taps in use and a signal far shorter than the window: only the flush
		// produces outputs, and every one of them is still seen.
		load_coef(0, 65536);
		set_taps(HALF_TAPS);
		send_sample(32767, 1'b0);
		send_sample(-32768, 1'b0);
		send_sample(12345, 1'b1);

		// Random part, one phase per idling pattern. Each phase rewrites the tap count at most
		// once in the middle of an open signal, and phase 1 always does so.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = send_pct[p];
			recv_stall_pct = recv_pct[p];
			set_taps(phase_taps[p]);
			start_count = loads_sent + samples_sent;
			mid_done = 1'b0;
			// A long signal drives the sample count into saturation, and the tap count
			// changes while it is still open.
			if (p == 1) begin
				send_signal(130, 1'b0);
				set_taps($urandom_range(HALF_TAPS, 0));
				send_signal(rand_length(), 1'b1);
				mid_done = 1'b1;
			end
			while (loads_sent + samples_sent - start_count < PHASE_ITEMS) begin
				if (!mid_done && loads_sent + samples_sent - start_count >= PHASE_ITEMS / 2) begin
					send_signal($urandom_range(6, 1), 1'b0);
					set_taps($urandom_range(HALF_TAPS, 0));
					mid_done = 1'b1;
				end
				send_signal(rand_length(), 1'b1);
			end
		end

		wait_quiet();

		$display("Sent %0d coefficient loads and %0d samples in %0d signals over %0d tap settings.",
			loads_sent, samples_sent, signals_sent, tap_settings);
		$display("Compared %0d filtered samples, %0d of them clipped.",
			results_checked, saturations);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Hard stop in case the filter hangs or a result never arrives.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout with %0d results still outstanding.", pending);
		$display("Regression FAIL");
		$finish;
	end

endmodule
